// ===== hw/rtl/fpll_pkg.sv =====
// Shared types and constants of the four-pole ladder lowpass: item structs,
// datapath control word, enum codes and fixed-point widths.
// No dependencies; compile first.
package fpll_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CH_FIELD_W = 4;
    localparam int COEF_W     = 32;
    localparam int STATE_W    = 32;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int TERM_W     = PROD_W - FRAC_W;
    localparam int ACC_W      = TERM_W + 2;
    localparam int STAGE_W    = 2;
    localparam int WORD_W     = STAGE_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [STAGE_W-1:0] LAST_STAGE = 2'd3;

    localparam logic signed [COEF_W-1:0] Q24_POINT_THREE     = 32'sd5033165;
    localparam logic signed [COEF_W-1:0] RESET_ONE_MINUS_F   = 32'sd14229763;
    localparam logic signed [COEF_W-1:0] RESET_FEEDBACK_COEF = 32'sd1671921;
    localparam logic signed [COEF_W-1:0] RESET_INPUT_GAIN    = 32'sd3123;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_MINUS_F   = 2'd0,
        REG_FEEDBACK_COEF = 2'd1,
        REG_INPUT_GAIN    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        op_t                         op;
        logic [CH_FIELD_W-1:0]       channel;
        logic signed [SAMPLE_W-1:0]  sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic [CH_FIELD_W-1:0]       channel_out;
    } out_item_t;

    // which state word of the current channel a memory access touches
    typedef enum logic [1:0] {
        W_OUT4  = 2'd0,
        W_IN_K  = 2'd1,
        W_OUT_K = 2'd2
    } word_sel_t;

    typedef enum logic {
        WD_Y   = 1'b0,
        WD_SAT = 1'b1
    } wdata_sel_t;

    typedef enum logic {
        MA_MEM = 1'b0,
        MA_Y   = 1'b1
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_FEEDBACK    = 2'd0,
        MB_GAIN        = 2'd1,
        MB_POINT_THREE = 2'd2,
        MB_POLE        = 2'd3
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_X2        = 3'd1,
        ACC_SUB       = 3'd2,
        ACC_ADD       = 3'd3,
        ACC_LOAD_TERM = 3'd4,
        ACC_LOAD_Y    = 3'd5
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT   = 2'd0,
        J_BYPASS = 2'd1,
        J_LOOP   = 2'd2,
        J_END    = 2'd3
    } jump_t;

    typedef struct packed {
        logic        rd_en;
        word_sel_t   rd_sel;
        logic        wr_en;
        word_sel_t   wr_sel;
        wdata_sel_t  wr_data;
        logic        mul_en;
        mul_a_t      mul_a;
        mul_b_t      mul_b;
        acc_op_t     acc_op;
        logic        y_ld;
        logic        set_row;
        logic        clr_row;
    } dp_ctl_t;

    typedef struct packed {
        dp_ctl_t               ctl;
        logic [STAGE_W-1:0]    stage;
    } dp_cmd_t;

endpackage

// ===== hw/rtl/fpll_seq.sv =====
// Microcode sequencer of the ladder lowpass: program ROM, step counter,
// pole-stage loop counter and jump logic. Depends on fpll_pkg.
module fpll_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              bypass,
    input  logic              out_free,
    output logic              busy,
    output logic              done,
    output fpll_pkg::dp_cmd_t cmd
);
    import fpll_pkg::*;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] P_LOOP = 5'd9;
    localparam logic [PC_W-1:0] P_CLR  = 5'd16;

    typedef struct packed {
        dp_ctl_t          ctl;
        jump_t            jmp;
        logic [PC_W-1:0]  target;
        logic             stage_clr;
    } uop_t;

    // One control word per step. A multiply lands in the product register in the
    // next step and in the rounded term register the step after that.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u = '0;
        unique case (pc)
            5'd0: begin
                u.ctl.rd_en  = 1'b1;
                u.ctl.rd_sel = W_OUT4;
                u.ctl.acc_op = ACC_X2;
                u.jmp        = J_BYPASS;
                u.target     = P_CLR;
            end
            5'd1: begin
                u.ctl.mul_en = 1'b1;
                u.ctl.mul_a  = MA_MEM;
                u.ctl.mul_b  = MB_FEEDBACK;
            end
            5'd2: begin
            end
            5'd3: begin
                u.ctl.acc_op = ACC_SUB;
            end
            5'd4: begin
                u.ctl.y_ld = 1'b1;
            end
            5'd5: begin
                u.ctl.mul_en = 1'b1;
                u.ctl.mul_a  = MA_Y;
                u.ctl.mul_b  = MB_GAIN;
            end
            5'd6: begin
            end
            5'd7: begin
                u.ctl.acc_op = ACC_LOAD_TERM;
            end
            5'd8: begin
                u.ctl.y_ld  = 1'b1;
                u.stage_clr = 1'b1;
            end
            // pole stage loop body
            5'd9: begin
                u.ctl.rd_en  = 1'b1;
                u.ctl.rd_sel = W_IN_K;
                u.ctl.acc_op = ACC_LOAD_Y;
            end
            5'd10: begin
                u.ctl.rd_en   = 1'b1;
                u.ctl.rd_sel  = W_OUT_K;
                u.ctl.mul_en  = 1'b1;
                u.ctl.mul_a   = MA_MEM;
                u.ctl.mul_b   = MB_POINT_THREE;
                u.ctl.wr_en   = 1'b1;
                u.ctl.wr_sel  = W_IN_K;
                u.ctl.wr_data = WD_Y;
            end
            5'd11: begin
                u.ctl.mul_en = 1'b1;
                u.ctl.mul_a  = MA_MEM;
                u.ctl.mul_b  = MB_POLE;
            end
            5'd12: begin
                u.ctl.acc_op = ACC_ADD;
            end
            5'd13: begin
                u.ctl.acc_op = ACC_ADD;
            end
            5'd14: begin
                u.ctl.y_ld    = 1'b1;
                u.ctl.wr_en   = 1'b1;
                u.ctl.wr_sel  = W_OUT_K;
                u.ctl.wr_data = WD_SAT;
                u.jmp         = J_LOOP;
                u.target      = P_LOOP;
            end
            5'd15: begin
                u.ctl.set_row = 1'b1;
                u.jmp         = J_END;
            end
            5'd16: begin
                u.ctl.clr_row = 1'b1;
                u.jmp         = J_END;
            end
            default: begin
                u.jmp = J_END;
            end
        endcase
        return u;
    endfunction

    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [STAGE_W-1:0]  stage_reg, stage_next;
    uop_t                uop;

    assign uop = ucode(pc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pc_reg    <= '0;
            stage_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        stage_next = stage_reg;
        done       = 1'b0;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else begin
            if (uop.stage_clr) begin
                stage_next = '0;
            end
            unique case (uop.jmp)
                J_NEXT: begin
                    pc_next = pc_reg + 1'b1;
                end
                J_BYPASS: begin
                    pc_next = bypass ? uop.target : pc_reg + 1'b1;
                end
                J_LOOP: begin
                    if (stage_reg != LAST_STAGE) begin
                        pc_next    = uop.target;
                        stage_next = stage_reg + 1'b1;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                J_END: begin
                    // hold here until the output register can take the result
                    if (out_free) begin
                        done      = 1'b1;
                        busy_next = 1'b0;
                    end
                end
            endcase
        end
    end

    assign busy      = busy_reg;
    assign cmd.ctl   = busy_reg ? uop.ctl : '0;
    assign cmd.stage = stage_reg;

`ifndef ASSERT_OFF
    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= P_CLR)
        else $error("sequencer ran past the end of the program");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !busy_reg)
        else $error("sequencer still busy after delivering a result");

    a_start_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy_reg && pc_reg == '0))
        else $error("request did not start the program at its entry step");
`endif

endmodule

// ===== hw/rtl/fpll_dp.sv =====
// Datapath of the ladder lowpass: per-channel state memory with row valid
// bits, shared multiplier, rounding, accumulator and saturation. Uses fpll_pkg.
module fpll_dp #(
    parameter int CHANNELS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fpll_pkg::dp_cmd_t                     cmd,
    input  logic [fpll_pkg::CH_FIELD_W-1:0]       channel,
    input  logic signed [fpll_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                  in_range,
    input  logic signed [fpll_pkg::COEF_W-1:0]    one_minus_f,
    input  logic signed [fpll_pkg::COEF_W-1:0]    feedback_coef,
    input  logic signed [fpll_pkg::COEF_W-1:0]    input_gain,
    output logic signed [fpll_pkg::SAMPLE_W-1:0]  sample_out
);
    import fpll_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW    = CH_W + WORD_W;
    localparam int DEPTH = CHANNELS * (2 ** WORD_W);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_W - 1));

    function automatic logic [WORD_W-1:0] word_addr(input word_sel_t sel,
                                                    input logic [STAGE_W-1:0] stage);
        logic [WORD_W-1:0] w;
        unique case (sel)
            W_OUT4:  w = {1'b1, LAST_STAGE};
            W_IN_K:  w = {1'b0, stage};
            W_OUT_K: w = {1'b1, stage};
            default: w = {1'b1, LAST_STAGE};
        endcase
        return w;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] top;
        top = v[ACC_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return v[STATE_W-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    logic [CH_W-1:0]             ch_idx;
    logic [CHANNELS-1:0]         row_valid_reg;
    logic [STATE_W-1:0]          mem [DEPTH];
    logic [STATE_W-1:0]          mem_q_reg;
    logic [AW-1:0]               rd_addr, wr_addr;
    logic signed [STATE_W-1:0]   mem_rd;
    logic signed [STATE_W-1:0]   wr_word;
    logic signed [COEF_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    round_sum;
    logic signed [TERM_W-1:0]    term_reg;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [STATE_W-1:0]   acc_sat;
    logic signed [STATE_W-1:0]   y_reg;
    logic signed [STATE_W:0]     y_round;
    logic signed [STATE_W-1:0]   y_half;

    assign ch_idx  = CH_W'(channel);
    assign rd_addr = {ch_idx, word_addr(cmd.ctl.rd_sel, cmd.stage)};
    assign wr_addr = {ch_idx, word_addr(cmd.ctl.wr_sel, cmd.stage)};

    // a row never written since reset or since its last clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (in_range) begin
            if (cmd.ctl.set_row) begin
                row_valid_reg[ch_idx] <= 1'b1;
            end else if (cmd.ctl.clr_row) begin
                row_valid_reg[ch_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ctl.wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.ctl.rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign mem_rd  = row_valid_reg[ch_idx] ? $signed(mem_q_reg) : '0;
    assign acc_sat = sat_state(acc_reg);
    assign wr_word = (cmd.ctl.wr_data == WD_Y) ? y_reg : acc_sat;

    assign mul_a = (cmd.ctl.mul_a == MA_MEM) ? mem_rd : y_reg;

    always_comb begin
        unique case (cmd.ctl.mul_b)
            MB_FEEDBACK:    mul_b = feedback_coef;
            MB_GAIN:        mul_b = input_gain;
            MB_POINT_THREE: mul_b = Q24_POINT_THREE;
            MB_POLE:        mul_b = one_minus_f;
        endcase
    end

    // round half up: add half an LSB, then drop the fraction with floor
    assign round_sum = prod_reg + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (cmd.ctl.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        term_reg <= round_sum[PROD_W-1:FRAC_W];
        acc_reg  <= acc_next;
        if (cmd.ctl.y_ld) begin
            y_reg <= acc_sat;
        end
    end

    always_comb begin
        unique case (cmd.ctl.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_X2:        acc_next = ACC_W'(sample_in) <<< 1;
            ACC_SUB:       acc_next = acc_reg - ACC_W'(term_reg);
            ACC_ADD:       acc_next = acc_reg + ACC_W'(term_reg);
            ACC_LOAD_TERM: acc_next = ACC_W'(term_reg);
            ACC_LOAD_Y:    acc_next = ACC_W'(y_reg);
            default:       acc_next = acc_reg;
        endcase
    end

    // Q8.24 back to Q1.23, round half up, saturate to the sample range
    assign y_round = (STATE_W + 1)'(y_reg) + (STATE_W + 1)'(1);
    assign y_half  = y_round[STATE_W:1];

    always_comb begin
        if ((&y_half[STATE_W-1:SAMPLE_W-1]) || !(|y_half[STATE_W-1:SAMPLE_W-1])) begin
            sample_out = y_half[SAMPLE_W-1:0];
        end else if (y_half[STATE_W-1]) begin
            sample_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sample_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule

// ===== hw/rtl/four_pole_ladder_lowpass_top.sv =====
// Four-pole resonant ladder lowpass, multichannel, Q1.23 samples with
// Q8.24 state: one request is taken while the block is idle and runs a short
// microcoded program on one shared 32x32 multiplier and a one-read, one-write
// state memory; a filter request runs four pole stages at six steps each plus
// nine steps of feedback and gain and one step that posts the result, while a
// clear request or a channel at or beyond CHANNELS runs only the entry step
// and one step that posts the result. The next request can be taken once the
// result is posted. A result still waiting in the output register holds the
// program at its last step. Each pole stage needs two products, each read
// through the single multiplier and a registered rounding step. Per-channel
// state starts at zero after reset with no clearing pass (a valid bit per
// channel). The output register lets a new request in while a result waits
// to be taken. Coefficients must be written on the cfg channel only while no
// request is in flight; the block itself does not enforce this.
module four_pole_ladder_lowpass_top #(
    parameter int CHANNELS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fpll_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fpll_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpll_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpll_pkg::COEF_W-1:0]         cfg_data
);
    import fpll_pkg::*;

    in_item_t                   item_reg;
    out_item_t                  m_data_reg;
    logic                       m_valid_reg;
    logic signed [COEF_W-1:0]   one_minus_f_reg;
    logic signed [COEF_W-1:0]   feedback_coef_reg;
    logic signed [COEF_W-1:0]   input_gain_reg;
    logic                       accept;
    logic                       busy;
    logic                       done;
    logic                       out_free;
    logic                       in_range;
    logic                       bypass;
    dp_cmd_t                    cmd;
    logic signed [SAMPLE_W-1:0] dp_sample;

    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign in_range = 32'(item_reg.channel) < 32'(CHANNELS);
    assign bypass   = (item_reg.op == OP_CLEAR) || !in_range;

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_minus_f_reg   <= RESET_ONE_MINUS_F;
            feedback_coef_reg <= RESET_FEEDBACK_COEF;
            input_gain_reg    <= RESET_INPUT_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ONE_MINUS_F:   one_minus_f_reg   <= $signed(cfg_data);
                REG_FEEDBACK_COEF: feedback_coef_reg <= $signed(cfg_data);
                REG_INPUT_GAIN:    input_gain_reg    <= $signed(cfg_data);
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    fpll_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .bypass   (bypass),
        .out_free (out_free),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    fpll_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .channel       (item_reg.channel),
        .sample_in     (item_reg.sample_in),
        .in_range      (in_range),
        .one_minus_f   (one_minus_f_reg),
        .feedback_coef (feedback_coef_reg),
        .input_gain    (input_gain_reg),
        .sample_out    (dp_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg.sample_out  <= bypass ? '0 : dp_sample;
            m_data_reg.channel_out <= item_reg.channel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted but block did not go busy");

    a_result_posted: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid)
        else $error("finished request did not reach the output register");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting result dropped or changed before it was taken");
`endif

endmodule

// ===== verif/four_pole_ladder_lowpass_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for four_pole_ladder_lowpass_top: random and directed sample
// and clear requests, coefficient writes, and a bit-exact fixed-point ladder predictor.
// Depends on fpll_pkg and the top-level RTL.
module four_pole_ladder_lowpass_top_test;
    import fpll_pkg::*;

    localparam int CHANNELS = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic signed [COEF_W-1:0] Q24_ONE = 32'sd16777216;

    class ladder_scoreboard;
        logic signed [COEF_W-1:0]  pole_coef;
        logic signed [COEF_W-1:0]  fb_coef;
        logic signed [COEF_W-1:0]  gain_coef;
        logic signed [STATE_W-1:0] prev_in  [CHANNELS][4];
        logic signed [STATE_W-1:0] prev_out [CHANNELS][4];
        out_item_t                 expected_q [$];
        int                        failures;

        function new();
            pole_coef = RESET_ONE_MINUS_F;
            fb_coef   = RESET_FEEDBACK_COEF;
            gain_coef = RESET_INPUT_GAIN;
            failures  = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                clear_channel(c);
            end
        endfunction

        function void clear_channel(int ch);
            for (int k = 0; k < 4; k++) begin
                prev_in[ch][k]  = '0;
                prev_out[ch][k] = '0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Q8.24 product, round half up
        function longint round_mul(longint a, longint b);
            longint p;
            p = a * b + (longint'(1) <<< 23);
            return p >>> 24;
        endfunction

        function logic signed [STATE_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [STATE_W-1:0] one_pole(int ch, int k,
                                                     logic signed [STATE_W-1:0] x);
            logic signed [STATE_W-1:0] y;
            y = clamp32(longint'(x) + round_mul(Q24_POINT_THREE, prev_in[ch][k])
                        + round_mul(pole_coef, prev_out[ch][k]));
            prev_in[ch][k]  = x;
            prev_out[ch][k] = y;
            return y;
        endfunction

        function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            case (idx)
                REG_ONE_MINUS_F:   pole_coef = val;
                REG_FEEDBACK_COEF: fb_coef   = val;
                REG_INPUT_GAIN:    gain_coef = val;
                default: ;
            endcase
        endfunction

        function void note_request(in_item_t it);
            out_item_t                 r;
            logic signed [STATE_W-1:0] t;
            longint                    q;
            int                        ch;
            ch            = it.channel;
            r.channel_out = it.channel;
            r.sample_out  = '0;
            if (ch < CHANNELS) begin
                if (it.op == OP_CLEAR) begin
                    clear_channel(ch);
                end else begin
                    t = clamp32(longint'(it.sample_in) * 2
                                - round_mul(prev_out[ch][3], fb_coef));
                    t = clamp32(round_mul(t, gain_coef));
                    for (int k = 0; k < 4; k++) begin
                        t = one_pole(ch, k, t);
                    end
                    q = (longint'(t) + 1) >>> 1;
                    if (q > 64'sd8388607) q = 64'sd8388607;
                    if (q < -64'sd8388608) q = -64'sd8388608;
                    r.sample_out = q[23:0];
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: sample_out %0d channel_out %0d",
                         $time, got.sample_out, got.channel_out);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.sample_out !== exp_r.sample_out) begin
                $display("%0t: sample_out mismatch: expected %0d actual %0d (channel %0d)",
                         $time, exp_r.sample_out, got.sample_out, exp_r.channel_out);
                failures++;
            end
            if (got.channel_out !== exp_r.channel_out) begin
                $display("%0t: channel_out mismatch: expected %0d actual %0d",
                         $time, exp_r.channel_out, got.channel_out);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COEF_W-1:0]      cfg_data;

    ladder_scoreboard sb = new();
    bit idle_on;
    int hold_cycles;

    four_pole_ladder_lowpass_top #(.CHANNELS(CHANNELS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // results leave before new requests update the channel state
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (cfg_valid && cfg_ready) sb.write_coef(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_request(s_data);
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'(int'($urandom_range(0, 1023)) - 512);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic [CH_FIELD_W-1:0] ch,
                                input logic signed [SAMPLE_W-1:0] x);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_data.op         = op;
        s_data.channel    = ch;
        s_data.sample_in  = x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and hold until every expected result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_coefs(input logic [COEF_W-1:0] pole, input logic [COEF_W-1:0] fb,
                             input logic [COEF_W-1:0] gain);
        wait_drained();
        write_reg(REG_ONE_MINUS_F, pole);
        write_reg(REG_FEEDBACK_COEF, fb);
        write_reg(REG_INPUT_GAIN, gain);
    endtask

    task automatic run_random(input int n);
        op_t                   op;
        logic [CH_FIELD_W-1:0] ch;
        repeat (n) begin
            op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_FILTER;
            // favor a few channels so their state runs deep
            ch = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom());
            send_request(op, ch, pick_sample());
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset coefficients
        repeat (3) send_request(OP_FILTER, 4'd0, 24'sh7FFFFF);
        send_request(OP_FILTER, 4'd0, 24'sh800000);
        send_request(OP_FILTER, 4'd0, 24'sd0);
        send_request(OP_FILTER, 4'd15, 24'sh7FFFFF);
        send_request(OP_FILTER, 4'd15, 24'sh800000);
        send_request(OP_CLEAR, 4'd0, 24'sh555555);
        send_request(OP_FILTER, 4'd0, -24'sd1);
        send_request(OP_CLEAR, 4'd9, 24'shAAAAAA);

        // unity gain, strong resonance: drive toward saturation
        set_coefs(32'sd13421773, 32'sd50331648, Q24_ONE);
        repeat (6) send_request(OP_FILTER, 4'd1, 24'sh7FFFFF);
        repeat (4) send_request(OP_FILTER, 4'd1, 24'sh800000);
        send_request(OP_CLEAR, 4'd1, 24'sd0);
        send_request(OP_FILTER, 4'd1, 24'sd1);
        run_random(100);
        hold_cycles = 400;
        run_random(100);

        set_coefs(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        run_random(75);
        wait_drained();
        run_random(75);

        set_coefs(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        write_reg(REG_SPARE, $urandom());
        run_random(150);

        set_coefs($urandom(), $urandom(), $urandom());
        run_random(150);

        set_coefs($urandom_range(0, 16777216), $urandom_range(0, 67108864),
                  $urandom_range(0, 16777216));
        run_random(200);

        // last stretch without idling
        set_coefs(RESET_ONE_MINUS_F, RESET_FEEDBACK_COEF, 32'sd8388608);
        idle_on = 1'b0;
        run_random(230);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
